// ===== src/mucr_pkg.sv =====
package mucr_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int WHEEL_DEPTH  = 16;

    localparam int PIN_W    = 32;
    localparam int CHAN_W   = 5;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 4;
    localparam int BITCNT_W = 4;
    localparam int BITIDX_W = 3;
    localparam int TIMER_W  = (WHEEL_DEPTH > 1) ? $clog2(WHEEL_DEPTH) : 1;

    // Bit count at which the stop bit is due
    localparam logic [BITCNT_W-1:0] STOP_COUNT = BITCNT_W'(BYTE_W + 1);

    localparam logic [CFG_W-1:0] START_DELAY_RESET = CFG_W'(4);
    localparam logic [CFG_W-1:0] BIT_PERIOD_RESET  = CFG_W'(8);

    // Configuration register indexes
    localparam logic REG_START_DELAY = 1'b0;
    localparam logic REG_BIT_PERIOD  = 1'b1;

    typedef struct packed {
        logic [TIMER_W-1:0] start_off;
        logic [TIMER_W-1:0] period_off;
    } lane_cfg_t;

    typedef struct packed {
        logic              done;
        logic              ferr;
        logic [BYTE_W-1:0] data;
    } lane_res_t;

    // Reduce a register value modulo the wheel depth by repeated subtraction
    function automatic logic [TIMER_W-1:0] wheel_mod(input logic [CFG_W-1:0] value);
        logic [CFG_W:0] v;
        v = {1'b0, value};
        for (int k = 0; k < 8; k++)
        begin
            if (32'(v) >= WHEEL_DEPTH)
            begin
                v = v - (CFG_W+1)'(WHEEL_DEPTH);
            end
        end
        return TIMER_W'(v);
    endfunction

endpackage

// ===== src/mucr_lane.sv =====
module mucr_lane
    import mucr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic      level,
    input  lane_cfg_t cfg,
    input  logic      take,
    output lane_res_t res
);

    logic                prev_reg, prev_next;
    logic                busy_reg, busy_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [BITCNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;
    logic                done_reg, done_next;
    logic                ferr_reg, ferr_next;

    logic                start;
    logic                due;
    logic [BITCNT_W-1:0] count_cur;
    logic [BYTE_W-1:0]   byte_cur;
    logic [BITIDX_W-1:0] bit_idx;

    always_comb
    begin
        prev_next  = prev_reg;
        busy_next  = busy_reg;
        timer_next = timer_reg;
        count_next = count_reg;
        byte_next  = byte_reg;
        done_next  = done_reg & ~take;
        ferr_next  = ferr_reg;

        start     = prev_reg & ~level & ~busy_reg;
        due       = 1'b0;
        count_cur = count_reg;
        byte_cur  = byte_reg;
        bit_idx   = BITIDX_W'(count_reg - BITCNT_W'(1));

        if (step)
        begin
            prev_next = level;
            if (start)
            begin
                busy_next  = 1'b1;
                count_cur  = '0;
                byte_cur   = '0;
                count_next = '0;
                byte_next  = '0;
                timer_next = cfg.start_off;
                due        = (cfg.start_off == '0);
            end
            else if (busy_reg)
            begin
                due = (timer_reg == TIMER_W'(1));
                // count down modulo the wheel depth
                timer_next = (timer_reg == '0) ? TIMER_W'(WHEEL_DEPTH - 1)
                                               : timer_reg - TIMER_W'(1);
            end

            if (due)
            begin
                if (count_cur == '0)
                begin
                    if (!level)
                    begin
                        count_next = BITCNT_W'(1);
                        timer_next = cfg.period_off;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                else if (count_cur < STOP_COUNT)
                begin
                    byte_next          = byte_cur;
                    byte_next[bit_idx] = byte_cur[bit_idx] | level;
                    count_next         = count_cur + BITCNT_W'(1);
                    timer_next         = cfg.period_off;
                end
                else
                begin
                    done_next = 1'b1;
                    ferr_next = ~level;
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 1'b1;
            busy_reg  <= 1'b0;
            timer_reg <= '0;
            count_reg <= '0;
            byte_reg  <= '0;
            done_reg  <= 1'b0;
            ferr_reg  <= 1'b0;
        end
        else
        begin
            prev_reg  <= prev_next;
            busy_reg  <= busy_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
            byte_reg  <= byte_next;
            done_reg  <= done_next;
            ferr_reg  <= ferr_next;
        end
    end

    assign res.done = done_reg;
    assign res.ferr = ferr_reg;
    assign res.data = ferr_reg ? '0 : byte_reg;

endmodule

// ===== src/mucr_merge.sv =====
module mucr_merge
    import mucr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_res_t               res [NUM_CHANNELS],
    output logic [NUM_CHANNELS-1:0] take,
    output logic                    busy,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CHAN_W-1:0]       channel,
    output logic [BYTE_W-1:0]       data_byte,
    output logic                    framing_error,
    output logic                    last_result
);

    logic                    valid_reg, valid_next;
    logic [CHAN_W-1:0]       chan_reg;
    logic [BYTE_W-1:0]       data_reg;
    logic                    ferr_reg;
    logic                    last_reg;

    logic [NUM_CHANNELS-1:0] pending;
    logic [NUM_CHANNELS-1:0] sel_oh;
    logic                    found;
    logic [CHAN_W-1:0]       sel_chan;
    logic [BYTE_W-1:0]       sel_data;
    logic                    sel_ferr;
    logic                    load;

    // Pick the lowest pending channel
    always_comb
    begin
        found    = 1'b0;
        sel_oh   = '0;
        sel_chan = '0;
        sel_data = '0;
        sel_ferr = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            pending[i] = res[i].done;
            if (res[i].done && !found)
            begin
                found     = 1'b1;
                sel_oh[i] = 1'b1;
                sel_chan  = CHAN_W'(i);
                sel_data  = res[i].data;
                sel_ferr  = res[i].ferr;
            end
        end
    end

    assign load       = found && (!valid_reg || out_ready);
    assign take       = load ? sel_oh : '0;
    assign busy       = found;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chan_reg <= sel_chan;
            data_reg <= sel_data;
            ferr_reg <= sel_ferr;
            last_reg <= ((pending & ~sel_oh) == '0);
        end
    end

    assign out_valid     = valid_reg;
    assign channel       = chan_reg;
    assign data_byte     = data_reg;
    assign framing_error = ferr_reg;
    assign last_result   = last_reg;

endmodule

// ===== src/multichannel_uart_receiver_core.sv =====
// Receiver for 32 oversampled 8N1 serial lines. Each input word is one sample
// of every receive pin; a falling edge on an idle line starts a frame, the
// start bit is checked start_delay samples later (a high level there drops
// the frame as a glitch), then eight data bits LSB first and the stop bit
// are taken every bit_period samples. A start_delay of zero checks the start
// bit on the falling-edge sample itself; a bit_period of zero means a full
// turn of the 16-sample schedule. Each finished frame gives one output word
// (channel, byte, framing error); a low stop bit gives a framing error and a
// zero byte. Words caused by one sample leave in ascending channel order, the
// final one marked by last_result. Timing: a sample is absorbed by all lanes
// at once, and the merge stage then hands out one finished frame per cycle
// while the output is not stalled; the next sample is taken as soon as every
// word of the previous one has reached the output register. Write the
// configuration registers only while the receiver is idle.
module multichannel_uart_receiver_core
    import mucr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // sample input
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PIN_W-1:0]  pin_sample,
    // result output
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAN_W-1:0] channel,
    output logic [BYTE_W-1:0] data_byte,
    output logic              framing_error,
    output logic              last_result,
    // configuration
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [CFG_W-1:0]        start_delay_reg, start_delay_next;
    logic [CFG_W-1:0]        bit_period_reg, bit_period_next;

    lane_cfg_t               lane_cfg;
    lane_res_t               lane_res [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] take;
    logic                    merge_busy;
    logic                    step;

    // Configuration registers
    always_comb
    begin
        start_delay_next = start_delay_reg;
        bit_period_next  = bit_period_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_START_DELAY: start_delay_next = cfg_data;
                REG_BIT_PERIOD:  bit_period_next  = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg <= START_DELAY_RESET;
            bit_period_reg  <= BIT_PERIOD_RESET;
        end
        else
        begin
            start_delay_reg <= start_delay_next;
            bit_period_reg  <= bit_period_next;
        end
    end

    // Fold the offsets onto the schedule length once, shared by all lanes
    assign lane_cfg.start_off  = wheel_mod(start_delay_reg);
    assign lane_cfg.period_off = wheel_mod(bit_period_reg);

    // Hold off new samples while finished frames still sit in the lanes
    assign in_ready = !merge_busy;
    assign step     = in_valid && in_ready;

    // One lane per channel; pins above the channel count are ignored
    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_lane
        mucr_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (step),
            .level (pin_sample[g]),
            .cfg   (lane_cfg),
            .take  (take[g]),
            .res   (lane_res[g])
        );
    end

    // Drain finished frames in ascending channel order
    mucr_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (lane_res),
        .take          (take),
        .busy          (merge_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel       (channel),
        .data_byte     (data_byte),
        .framing_error (framing_error),
        .last_result   (last_result)
    );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import mucr_pkg::*;

    // One finished frame as it leaves the receiver
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [BYTE_W-1:0] data;
        logic              ferr;
        logic              last;
    } frame_word_t;

    // One row of the directed table: a pin sample, and the word it must
    // produce where that can be typed in by hand
    typedef struct packed {
        logic [PIN_W-1:0] pins;
        logic             typed;
        frame_word_t      word;
    } pin_row_t;

    localparam frame_word_t NO_WORD = '0;

    // Directed part, run with start_delay = 1 and bit_period = 1, so that a
    // whole frame fits in eleven samples. The first frame falls on every
    // line at once straight out of reset and ends with a stop bit that is
    // low on the lower half (framing errors) and high on the upper half. The
    // second part overlaps a zero byte on channel 0, a glitch on channel 16
    // and an all-ones byte with a low stop bit on channel 31.
    localparam int DIR_ROWS_N = 25;
    localparam pin_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{32'h0000_0000, 1'b0, NO_WORD},
        '{32'h0000_0000, 1'b0, NO_WORD},
        '{32'h8000_FFFF, 1'b0, NO_WORD},
        '{32'hC3C2_A5A5, 1'b0, NO_WORD},
        '{32'hF0F0_5A5A, 1'b0, NO_WORD},
        '{32'hAAAA_0F0F, 1'b0, NO_WORD},
        '{32'h9998_F00F, 1'b0, NO_WORD},
        '{32'hFFFE_0000, 1'b0, NO_WORD},
        '{32'h8000_7E7E, 1'b0, NO_WORD},
        '{32'hDEAC_1234, 1'b0, NO_WORD},
        '{32'hFFFF_0000, 1'b0, NO_WORD},
        '{32'hFFFF_FFFF, 1'b0, NO_WORD},
        '{32'hFFFE_FFFE, 1'b0, NO_WORD},
        '{32'h7FFF_FFFE, 1'b0, NO_WORD},
        '{32'h7FFF_FFFE, 1'b0, NO_WORD},
        '{32'hFFFF_FFFE, 1'b0, NO_WORD},
        '{32'hFFFF_FFFE, 1'b0, NO_WORD},
        '{32'hFFFF_FFFE, 1'b0, NO_WORD},
        '{32'hFFFF_FFFE, 1'b0, NO_WORD},
        '{32'hFFFF_FFFE, 1'b0, NO_WORD},
        '{32'hFFFF_FFFE, 1'b0, NO_WORD},
        '{32'hFFFF_FFFE, 1'b0, NO_WORD},
        '{32'hFFFF_FFFF, 1'b1, '{5'd0, 8'h00, 1'b0, 1'b1}},
        '{32'h7FFF_FFFF, 1'b1, '{5'd31, 8'h00, 1'b1, 1'b1}},
        '{32'hFFFF_FFFF, 1'b0, NO_WORD}
    };

    // Register settings of the random phases: reset values, both extremes,
    // mixed extremes; the last entry is replaced by a random pair
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 45;
    localparam int PH_DELAY  [PHASES] = '{4, 1, 15, 1, 15, 0};
    localparam int PH_PERIOD [PHASES] = '{8, 1, 15, 15, 1, 0};

    localparam int SAMPLES_WANTED = 380;
    localparam int WORDS_WANTED   = 64;
    localparam int SAMPLES_CAP    = 4000;
    // Cycles to let the merge stage drain after the last word
    localparam int SETTLE_CYCLES  = 40;
    // Longest stretch with no handshake on either side before giving up
    localparam int QUIET_LIMIT    = 2000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [PIN_W-1:0]  pin_sample = '1;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] data_byte;
    logic              framing_error;
    logic              last_result;
    logic              cfg_write = 1'b0;
    logic              cfg_index = REG_START_DELAY;
    logic [CFG_W-1:0]  cfg_data = '0;

    multichannel_uart_receiver_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pin_sample    (pin_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel       (channel),
        .data_byte     (data_byte),
        .framing_error (framing_error),
        .last_result   (last_result),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Receiver prediction: a copy of the line state, the schedule wheel
    // and the two registers, advanced once per accepted sample
    // ------------------------------------------------------------------
    logic [PIN_W-1:0]  rx_prev;
    logic [PIN_W-1:0]  rx_busy;
    int                rx_pos;
    logic [PIN_W-1:0]  rx_wheel [WHEEL_DEPTH];
    logic [3:0]        rx_count [NUM_CHANNELS];
    logic [BYTE_W-1:0] rx_shift [NUM_CHANNELS];
    int                rx_delay;
    int                rx_period;

    frame_word_t       pending_words [$];
    int                mismatches;
    int                samples_sent;
    int                words_due;
    bit                gaps_on;

    // Work out the words one sample produces and advance the copy
    task automatic decode_pins(input logic [PIN_W-1:0] pins, output frame_word_t words [$]);
        logic [PIN_W-1:0] starts;
        logic [PIN_W-1:0] due;
        frame_word_t      w;
        words = {};
        // new frames: falling edge on an idle line
        starts = rx_prev & ~pins & ~rx_busy;
        rx_busy = rx_busy | starts;
        rx_wheel[(rx_pos + rx_delay) % WHEEL_DEPTH] |= starts;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (starts[c])
            begin
                rx_count[c] = '0;
                rx_shift[c] = '0;
            end
        end
        // take and clear the slot due now, then visit its lines in order
        due = rx_wheel[rx_pos];
        rx_wheel[rx_pos] = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (due[c])
            begin
                if (rx_count[c] == 0)
                begin
                    if (!pins[c])
                    begin
                        rx_count[c] = 4'd1;
                        rx_wheel[(rx_pos + rx_period) % WHEEL_DEPTH][c] = 1'b1;
                    end
                    else
                    begin
                        // high at the start check: drop as a glitch
                        rx_busy[c] = 1'b0;
                    end
                end
                else if (rx_count[c] <= 4'd8)
                begin
                    if (pins[c])
                        rx_shift[c][rx_count[c] - 4'd1] = 1'b1;
                    rx_count[c] = rx_count[c] + 4'd1;
                    rx_wheel[(rx_pos + rx_period) % WHEEL_DEPTH][c] = 1'b1;
                end
                else
                begin
                    // stop bit; any count past eight lands here too
                    w.chan = CHAN_W'(c);
                    w.data = pins[c] ? rx_shift[c] : '0;
                    w.ferr = !pins[c];
                    w.last = 1'b0;
                    words.push_back(w);
                    rx_busy[c] = 1'b0;
                end
            end
        end
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        rx_prev = pins;
        rx_pos = (rx_pos + 1) % WHEEL_DEPTH;
    endtask

    // ------------------------------------------------------------------
    // Line generators: each pin plays a list of bits, each held for a
    // number of samples, then rests high. Lists are frames (good or with a
    // low stop bit), short low glitches, noise, or idle high on inactive lines.
    // ------------------------------------------------------------------
    logic [NUM_CHANNELS-1:0] ln_active;
    logic              ln_level  [NUM_CHANNELS];
    logic              ln_resting[NUM_CHANNELS];
    logic [15:0]       ln_bits   [NUM_CHANNELS];
    int                ln_nbits  [NUM_CHANNELS];
    int                ln_hold   [NUM_CHANNELS];
    int                ln_left   [NUM_CHANNELS];

    task automatic next_pins(output logic [PIN_W-1:0] pins);
        int                pick;
        logic [BYTE_W-1:0] byt;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (ln_left[c] == 0 && ln_nbits[c] == 0)
            begin
                if (!ln_resting[c])
                begin
                    ln_resting[c] = 1'b1;
                    ln_level[c] = 1'b1;
                    ln_left[c] = $urandom_range(0, 2 * rx_period);
                end
                if (ln_left[c] == 0)
                begin
                    ln_resting[c] = 1'b0;
                    pick = $urandom_range(0, 99);
                    if (!ln_active[c])
                    begin
                        ln_bits[c] = '1;
                        ln_nbits[c] = 1;
                        ln_hold[c] = $urandom_range(1, 20);
                    end
                    else if (pick < 80)
                    begin
                        // frame: start, eight data bits LSB first, stop
                        byt = (pick < 4) ? 8'h00 : (pick < 8) ? 8'hFF : BYTE_W'($urandom);
                        ln_bits[c] = {6'b0, (pick < 64), byt, 1'b0};
                        ln_nbits[c] = 10;
                        // now and then a line runs at the wrong rate
                        ln_hold[c] = ($urandom_range(0, 9) == 0) ?
                                     $urandom_range(1, 15) : rx_period;
                    end
                    else if (pick < 90)
                    begin
                        // low pulse that is over by the start check
                        ln_bits[c] = '0;
                        ln_nbits[c] = 1;
                        ln_hold[c] = $urandom_range(1, (rx_delay > 0) ? rx_delay : 1);
                    end
                    else
                    begin
                        ln_bits[c] = 16'($urandom);
                        ln_nbits[c] = $urandom_range(2, 12);
                        ln_hold[c] = 1;
                    end
                end
            end
            if (ln_left[c] == 0)
            begin
                ln_level[c] = ln_bits[c][0];
                ln_bits[c] = ln_bits[c] >> 1;
                ln_nbits[c] = ln_nbits[c] - 1;
                ln_left[c] = ln_hold[c];
            end
            pins[c] = ln_level[c];
            ln_left[c] = ln_left[c] - 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Sample driver: starts and ends at a falling edge
    // ------------------------------------------------------------------
    task automatic send_pins(input logic [PIN_W-1:0] pins, input bit typed,
                             input frame_word_t typed_word);
        frame_word_t words [$];
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        pin_sample <= pins;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        decode_pins(pins, words);
        if (typed)
            words = '{typed_word};
        foreach (words[i])
            pending_words.push_back(words[i]);
        words_due += words.size();
        samples_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold until every word is out and the merge stage is quiet
    task automatic drain_words();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write both registers, start delay first, then bit period
    task automatic load_config(input int delay, input int period);
        cfg_write <= 1'b1;
        cfg_index <= REG_START_DELAY;
        cfg_data  <= CFG_W'(delay);
        @(negedge clk);
        cfg_index <= REG_BIT_PERIOD;
        cfg_data  <= CFG_W'(period);
        @(negedge clk);
        cfg_write <= 1'b0;
        rx_delay  = delay;
        rx_period = period;
    endtask

    // Pick which lines carry traffic in a phase: all, most or a few
    task automatic pick_lines();
        case ($urandom_range(0, 2))
            0: ln_active = '1;
            1: ln_active = $urandom | $urandom;
            default: ln_active = $urandom & $urandom;
        endcase
        ln_active[$urandom_range(0, NUM_CHANNELS - 1)] = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts while gaps are on
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (gaps_on && $urandom_range(0, 11) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare each word leaving the receiver with the oldest one due
    always @(posedge clk)
    begin : check_words
        frame_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: channel %0d, data_byte %0h, framing_error %0b",
                       channel, data_byte, framing_error);
                mismatches++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (channel !== want.chan)
                begin
                    $error("channel: expected %0d, got %0d", want.chan, channel);
                    mismatches++;
                end
                if (data_byte !== want.data)
                begin
                    $error("data_byte: expected %0h, got %0h", want.data, data_byte);
                    mismatches++;
                end
                if (framing_error !== want.ferr)
                begin
                    $error("framing_error: expected %0b, got %0b", want.ferr, framing_error);
                    mismatches++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result: expected %0b, got %0b", want.last, last_result);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no handshake at all
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          final_count;
        int          delay;
        int          period;
        logic [PIN_W-1:0] pins;

        mismatches   = 0;
        samples_sent = 0;
        words_due    = 0;
        gaps_on      = 1'b1;
        final_count  = 0;

        // reset state of the copy
        rx_prev   = '1;
        rx_busy   = '0;
        rx_pos    = 0;
        rx_delay  = START_DELAY_RESET;
        rx_period = BIT_PERIOD_RESET;
        for (int i = 0; i < WHEEL_DEPTH; i++)
            rx_wheel[i] = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            rx_count[c]   = '0;
            rx_shift[c]   = '0;
            ln_level[c]   = 1'b1;
            ln_resting[c] = 1'b1;
            ln_bits[c]    = '1;
            ln_nbits[c]   = 0;
            ln_hold[c]    = 1;
            ln_left[c]    = 0;
        end
        ln_active = '1;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table at start_delay = 1 and bit_period = 1
        load_config(1, 1);
        for (int r = 0; r < DIR_ROWS_N; r++)
            send_pins(DIR_ROWS[r].pins, DIR_ROWS[r].typed, DIR_ROWS[r].word);
        drain_words();

        // random phases, registers rewritten only once the receiver is quiet
        for (int p = 0; p < PHASES; p++)
        begin
            delay  = (PH_DELAY[p]  == 0) ? $urandom_range(1, 15) : PH_DELAY[p];
            period = (PH_PERIOD[p] == 0) ? $urandom_range(1, 15) : PH_PERIOD[p];
            load_config(delay, period);
            pick_lines();
            for (int k = 0; k < PHASE_LEN; k++)
            begin
                next_pins(pins);
                send_pins(pins, 1'b0, NO_WORD);
            end
            drain_words();
        end

        // last stretch runs flat out on both sides
        gaps_on = 1'b0;
        load_config($urandom_range(1, 15), $urandom_range(2, 12));
        ln_active = '1;
        while ((final_count < 60 || samples_sent < SAMPLES_WANTED || words_due < WORDS_WANTED)
               && samples_sent < SAMPLES_CAP)
        begin
            next_pins(pins);
            send_pins(pins, 1'b0, NO_WORD);
            final_count++;
        end
        drain_words();

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
